>>> design/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, constants and window helpers for the 3x3 LBP stream.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

   localparam int PIX_W           = 8;
   localparam int POS_W           = 10;
   localparam int CFG_W           = 11;
   localparam int CSR_INDEX_W     = 2;
   localparam int RST_IMAGE_WIDTH  = 640;
   localparam int RST_IMAGE_HEIGHT = 480;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_LVL_W = 3;

   // result queue
   localparam int OUT_DEPTH = 2;
   localparam int OUT_PTR_W = 1;
   localparam int OUT_LVL_W = 2;

   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] code;
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             last_of_run;
      logic             frame_done;
   } rsp_type;

   // one classified item for the back end
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
      logic             clr;     // first column: window starts from zero
      logic             e1;      // emit centre one column back
      logic             e2;      // end of row: emit the last column too
      logic             done;    // end of frame
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] col;
   } task_type;

   // [row][column], column 2 is the newest
   typedef logic [2:0][2:0][PIX_W-1:0] win_type;

   function automatic win_type win_shift(input win_type w, input logic [PIX_W-1:0] top,
                                         input logic [PIX_W-1:0] mid,
                                         input logic [PIX_W-1:0] bot);
      win_type r;
      for (int i = 0; i < 3; i++) begin
         r[i][0] = w[i][1];
         r[i][1] = w[i][2];
      end
      r[0][2] = top;
      r[1][2] = mid;
      r[2][2] = bot;
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] lbp_code(input win_type w);
      logic [PIX_W-1:0] c;
      logic [PIX_W-1:0] v;
      c    = w[1][1];
      v[7] = w[0][0] > c;
      v[6] = w[0][1] > c;
      v[5] = w[0][2] > c;
      v[4] = w[1][2] > c;
      v[3] = w[2][2] > c;
      v[2] = w[2][1] > c;
      v[1] = w[2][0] > c;
      v[0] = w[1][0] > c;
      return v;
   endfunction

endpackage

`default_nettype wire

>>> design/lbp_front.sv
// ----------------------------------------------------------------------------
// lbp_front
// Accepts items, keeps the raster counters and the line stores, and hands
// classified items with their column of pixels to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_push,
   output logic                                 req_full,
   input  lbp_pkg::req_type                     req_data,
   input  wire                                  csr_we,
   input  wire  [lbp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [lbp_pkg::CFG_W-1:0]            csr_data,
   input  wire  [lbp_pkg::QUEUE_LVL_W-1:0]      q_level,
   output logic                                 q_push,
   output lbp_pkg::task_type                    q_data
);

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RB = $clog2(MAX_HEIGHT);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int PW = lbp_pkg::PIX_W;
   localparam int W_RST = (lbp_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ?
                          MAX_WIDTH : lbp_pkg::RST_IMAGE_WIDTH;
   localparam int H_RST = (lbp_pkg::RST_IMAGE_HEIGHT > MAX_HEIGHT) ?
                          MAX_HEIGHT : lbp_pkg::RST_IMAGE_HEIGHT;

   logic [WW-1:0] w_ff, w_in;
   logic [HW-1:0] h_ff, h_in;
   logic [CB-1:0] col_ff, col_in;
   logic [CB-1:0] flush_ff, flush_in;
   logic [RB-1:0] row_ff, row_in;
   logic          drain_ff, drain_in;

   // line store: upper row in the high byte, middle row in the low byte
   logic [2*PW-1:0] mem [MAX_WIDTH];
   logic [2*PW-1:0] rd_ff;
   logic            fwd_ff;
   logic [2*PW-1:0] fwd_data_ff;

   logic              s1_valid_ff;
   logic              s1_wen_ff;
   logic [CB-1:0]     s1_addr_ff;
   logic [PW-1:0]     s1_pix_ff;
   logic              s1_ge1_ff;
   logic              s1_ge2_ff;
   lbp_pkg::task_type s1_ctrl_ff;
   lbp_pkg::task_type ctrl_in;

   logic            acc;
   logic            act;
   logic [CB-1:0]   cur_col;
   logic [HW-1:0]   cur_row;
   logic [WW-1:0]   col_inc;
   logic [HW-1:0]   row_inc;
   logic            end_row;
   logic            row_ge1;
   logic            row_ge2;
   logic [2*PW-1:0] rd_data;
   logic [2*PW-1:0] wdata;
   logic            mem_we;

   assign req_full = (q_level + lbp_pkg::QUEUE_LVL_W'(s1_valid_ff)) >=
                     lbp_pkg::QUEUE_LVL_W'(lbp_pkg::QUEUE_DEPTH);
   assign acc      = req_push & ~req_full;
   assign act      = acc & (req_data.kind == drain_ff);

   assign cur_col = drain_ff ? flush_ff : col_ff;
   assign cur_row = drain_ff ? h_ff : HW'(row_ff);
   assign col_inc = WW'(cur_col) + WW'(1);
   assign row_inc = HW'(row_ff) + HW'(1);
   assign end_row = col_inc >= w_ff;
   assign row_ge1 = cur_row != '0;
   assign row_ge2 = cur_row >= HW'(2);

   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      if (csr_we) begin
         case (csr_index)
            lbp_pkg::CSR_IMAGE_WIDTH: begin
               if (csr_data == '0) w_in = WW'(1);
               else if (csr_data > MAX_WIDTH) w_in = WW'(MAX_WIDTH);
               else w_in = WW'(csr_data);
            end
            lbp_pkg::CSR_IMAGE_HEIGHT: begin
               if (csr_data == '0) h_in = HW'(1);
               else if (csr_data > MAX_HEIGHT) h_in = HW'(MAX_HEIGHT);
               else h_in = HW'(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      flush_in = flush_ff;
      drain_in = drain_ff;
      if (act) begin
         if (end_row) begin
            if (drain_ff) begin
               col_in   = '0;
               row_in   = '0;
               flush_in = '0;
               drain_in = 1'b0;
            end else begin
               col_in = '0;
               if (row_inc >= h_ff) begin
                  drain_in = 1'b1;
                  flush_in = '0;
                  row_in   = '0;
               end else begin
                  row_in = row_inc[RB-1:0];
               end
            end
         end else if (drain_ff) begin
            flush_in = CB'(col_inc);
         end else begin
            col_in = CB'(col_inc);
         end
      end
   end

   always_comb begin
      ctrl_in         = '0;
      ctrl_in.bot     = drain_ff ? '0 : req_data.pixel;
      ctrl_in.clr     = cur_col == '0;
      ctrl_in.e1      = row_ge1 & (cur_col != '0);
      ctrl_in.e2      = row_ge1 & end_row;
      ctrl_in.done    = drain_ff & end_row;
      ctrl_in.out_row = lbp_pkg::POS_W'(cur_row - HW'(1));
      ctrl_in.col     = lbp_pkg::POS_W'(cur_col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff        <= WW'(W_RST);
         h_ff        <= HW'(H_RST);
         col_ff      <= '0;
         row_ff      <= '0;
         flush_ff    <= '0;
         drain_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
         s1_wen_ff   <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         w_ff        <= w_in;
         h_ff        <= h_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         flush_ff    <= flush_in;
         drain_ff    <= drain_in;
         s1_valid_ff <= act;
         s1_wen_ff   <= act & ~drain_ff;
         fwd_ff      <= mem_we && (s1_addr_ff == cur_col);
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wdata;
      s1_addr_ff  <= cur_col;
      s1_pix_ff   <= req_data.pixel;
      s1_ge1_ff   <= row_ge1;
      s1_ge2_ff   <= row_ge2;
      s1_ctrl_ff  <= ctrl_in;
   end

   // read-first line store; same-column write in flight is forwarded
   assign rd_data = fwd_ff ? fwd_data_ff : rd_ff;
   assign wdata   = {rd_data[PW-1:0], s1_pix_ff};
   assign mem_we  = s1_valid_ff & s1_wen_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[s1_addr_ff] <= wdata;
      end
      if (act) begin
         rd_ff <= mem[cur_col];
      end
   end

   always_comb begin
      q_data     = s1_ctrl_ff;
      q_data.top = s1_ge2_ff ? rd_data[2*PW-1:PW] : '0;
      q_data.mid = s1_ge1_ff ? rd_data[PW-1:0] : '0;
   end

   assign q_push = s1_valid_ff;

endmodule

`default_nettype wire

>>> design/lbp_queue.sv
// ----------------------------------------------------------------------------
// lbp_queue
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_queue (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  q_push,
   input  lbp_pkg::task_type                    q_data,
   input  wire                                  q_pop,
   output logic                                 q_empty,
   output lbp_pkg::task_type                    q_head,
   output logic [lbp_pkg::QUEUE_LVL_W-1:0]      q_level
);

   lbp_pkg::task_type                 q_mem [lbp_pkg::QUEUE_DEPTH];
   logic [lbp_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [lbp_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [lbp_pkg::QUEUE_LVL_W-1:0]   count_ff, count_in;

   assign q_empty = count_ff == '0;
   assign q_head  = q_mem[rd_ptr_ff];
   assign q_level = count_ff;

   always_comb begin
      count_in = count_ff;
      if (q_push && !q_pop) count_in = count_ff + lbp_pkg::QUEUE_LVL_W'(1);
      else if (!q_push && q_pop) count_in = count_ff - lbp_pkg::QUEUE_LVL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (q_push) wr_ptr_ff <= wr_ptr_ff + lbp_pkg::QUEUE_PTR_W'(1);
         if (q_pop)  rd_ptr_ff <= rd_ptr_ff + lbp_pkg::QUEUE_PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem[wr_ptr_ff] <= q_data;
      end
   end

endmodule

`default_nettype wire

>>> design/lbp_back.sv
// ----------------------------------------------------------------------------
// lbp_back
// Holds the 3x3 window, forms the codes and queues the result items.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_back (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  q_empty,
   input  lbp_pkg::task_type                    q_head,
   output logic                                 q_pop,
   output logic                                 rsp_empty,
   input  wire                                  rsp_pop,
   output lbp_pkg::rsp_type                     rsp_data
);

   localparam int POS_W = lbp_pkg::POS_W;

   lbp_pkg::win_type win_ff, win_in;
   lbp_pkg::win_type win_a, win_b, win_sel;
   logic             phase_ff, phase_in;
   logic [POS_W-1:0] p_row_ff;
   logic [POS_W-1:0] p_col_ff;
   logic             p_done_ff;

   lbp_pkg::rsp_type                o_mem [lbp_pkg::OUT_DEPTH];
   logic [lbp_pkg::OUT_PTR_W-1:0]   o_wr_ff;
   logic [lbp_pkg::OUT_PTR_W-1:0]   o_rd_ff;
   logic [lbp_pkg::OUT_LVL_W-1:0]   o_cnt_ff, o_cnt_in;

   logic             out_room;
   logic             go_a;
   logic             go_b;
   logic             o_push;
   logic             o_pop;
   lbp_pkg::rsp_type res;

   assign out_room = o_cnt_ff != lbp_pkg::OUT_LVL_W'(lbp_pkg::OUT_DEPTH);
   assign go_a     = ~phase_ff & ~q_empty & out_room;
   assign go_b     = phase_ff & out_room;
   assign q_pop    = go_a;

   assign win_a   = lbp_pkg::win_shift(q_head.clr ? '0 : win_ff,
                                       q_head.top, q_head.mid, q_head.bot);
   assign win_b   = lbp_pkg::win_shift(win_ff, '0, '0, '0);
   assign win_sel = phase_ff ? win_b : win_a;

   always_comb begin
      res.code        = lbp_pkg::lbp_code(win_sel);
      res.out_row     = phase_ff ? p_row_ff : q_head.out_row;
      res.out_col     = phase_ff ? p_col_ff : q_head.col - POS_W'(1);
      res.last_of_run = phase_ff | ~q_head.e2;
      res.frame_done  = phase_ff & p_done_ff;
   end

   assign o_push = go_b | (go_a & q_head.e1);

   always_comb begin
      win_in   = win_ff;
      phase_in = phase_ff;
      if (go_a) begin
         win_in   = win_a;
         phase_in = q_head.e2;
      end else if (go_b) begin
         win_in   = p_done_ff ? '0 : win_b;
         phase_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go_a) begin
         p_row_ff  <= q_head.out_row;
         p_col_ff  <= q_head.col;
         p_done_ff <= q_head.done;
      end
   end

   // result queue
   assign rsp_empty = o_cnt_ff == '0;
   assign rsp_data  = o_mem[o_rd_ff];
   assign o_pop     = rsp_pop & ~rsp_empty;

   always_comb begin
      o_cnt_in = o_cnt_ff;
      if (o_push && !o_pop) o_cnt_in = o_cnt_ff + lbp_pkg::OUT_LVL_W'(1);
      else if (!o_push && o_pop) o_cnt_in = o_cnt_ff - lbp_pkg::OUT_LVL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_wr_ff  <= '0;
         o_rd_ff  <= '0;
         o_cnt_ff <= '0;
      end else begin
         o_cnt_ff <= o_cnt_in;
         if (o_push) o_wr_ff <= o_wr_ff + lbp_pkg::OUT_PTR_W'(1);
         if (o_pop)  o_rd_ff <= o_rd_ff + lbp_pkg::OUT_PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (o_push) begin
         o_mem[o_wr_ff] <= res;
      end
   end

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end took an item from an empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      o_push |-> o_cnt_ff != lbp_pkg::OUT_LVL_W'(lbp_pkg::OUT_DEPTH))
      else $error("result queue overrun");

   a_row_end_phase: assert property (@(posedge clock) disable iff (reset)
      go_a && q_head.e2 |=> phase_ff)
      else $error("row end item did not enter second phase");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      go_b && p_done_ff |=> win_ff == '0)
      else $error("window not cleared after frame end");

endmodule

`default_nettype wire

>>> design/lbp_3x3_stream_top.sv
// ----------------------------------------------------------------------------
// lbp_3x3_stream_top
// Streaming 3x3 local binary pattern on 8-bit grey pixels in raster order.
//
//   channel   ports                                  direction
//   req       req_push, req_full, req_data           in  (pixel / flush item)
//   rsp       rsp_empty, rsp_pop, rsp_data           out (code, position)
//   csr       csr_valid, csr_ready, csr_index/data   in  (width, height)
//
// Takes one item per clock until the item queue fills; an end-of-row item
// holds the back end for a second phase, so a long run of rows stalls the
// input once the four-entry queue between front and back is full.
// A result reaches the ports through the line store read register, the item
// queue and the result queue; the end-of-row result comes from a second phase.
// Reset is synchronous; line stores are not cleared and need no clearing pass.
// Result stalls back up through the result queue and item queue to req_full.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_3x3_stream_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_push,
   output logic                                 req_full,
   input  lbp_pkg::req_type                     req_data,
   output logic                                 rsp_empty,
   input  wire                                  rsp_pop,
   output lbp_pkg::rsp_type                     rsp_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [lbp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [lbp_pkg::CFG_W-1:0]            csr_data
);

   logic                              q_push;
   lbp_pkg::task_type                 q_data;
   logic                              q_pop;
   logic                              q_empty;
   lbp_pkg::task_type                 q_head;
   logic [lbp_pkg::QUEUE_LVL_W-1:0]   q_level;
   logic                              csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   lbp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_level   (q_level),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   lbp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_level (q_level)
   );

   lbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> tb/tb_lbp_3x3_stream_top.sv
// ----------------------------------------------------------------------------
// tb_lbp_3x3_stream_top
// Self-checking bench for the streaming 3x3 LBP block. Frames of random size
// and content are pushed in raster order, followed by the flush items that
// drain the last row. A local line-store and window predictor works out every
// code, position and flag, and each popped item is checked against the oldest
// prediction. Covers the reset width, clamped sizes, ignored items, size
// changes inside a frame and random gaps on both sides.
// ----------------------------------------------------------------------------

module tb_lbp_3x3_stream_top;

   localparam int MAX_W = 1024;
   localparam int MAX_H = 1024;

   localparam logic [lbp_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [lbp_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_3 = 2'd3;

   typedef enum int {PIX_UNIFORM, PIX_NARROW, PIX_EXTREME, PIX_FLAT} pix_style_type;

   typedef logic [2:0][2:0][lbp_pkg::PIX_W-1:0] pix_window_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   lbp_pkg::req_type                req_data = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   lbp_pkg::rsp_type                rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [lbp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lbp_pkg::CFG_W-1:0]       csr_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int items_counted = 0;

   // predictor state
   logic [lbp_pkg::PIX_W-1:0] upper_row [0:MAX_W-1];
   logic [lbp_pkg::PIX_W-1:0] middle_row [0:MAX_W-1];
   pix_window_type            win_now;
   int unsigned               row_cnt;
   int unsigned               col_cnt;
   int unsigned               flush_cnt;
   bit                        draining;
   logic [lbp_pkg::CFG_W-1:0] width_reg;
   logic [lbp_pkg::CFG_W-1:0] height_reg;

   lbp_pkg::rsp_type lbp_results_due [$];

   lbp_3x3_stream_top #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned clamp_dim(input logic [lbp_pkg::CFG_W-1:0] v,
                                             input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [lbp_pkg::PIX_W-1:0] centre_code(input pix_window_type w);
      logic [lbp_pkg::PIX_W-1:0] c;
      c = w[1][1];
      return {w[0][0] > c, w[0][1] > c, w[0][2] > c, w[1][2] > c,
              w[2][2] > c, w[2][1] > c, w[2][0] > c, w[1][0] > c};
   endfunction

   task automatic push_column(input logic [lbp_pkg::PIX_W-1:0] top,
                              input logic [lbp_pkg::PIX_W-1:0] mid,
                              input logic [lbp_pkg::PIX_W-1:0] bot);
      for (int r = 0; r < 3; r++) begin
         win_now[r][0] = win_now[r][1];
         win_now[r][1] = win_now[r][2];
      end
      win_now[0][2] = top;
      win_now[1][2] = mid;
      win_now[2][2] = bot;
   endtask

   function automatic lbp_pkg::rsp_type make_result(input pix_window_type w,
                                                    input int unsigned row,
                                                    input int unsigned col,
                                                    input bit done);
      lbp_pkg::rsp_type r;
      r.code        = centre_code(w);
      r.out_row     = lbp_pkg::POS_W'(row);
      r.out_col     = lbp_pkg::POS_W'(col);
      r.last_of_run = 1'b0;
      r.frame_done  = done;
      return r;
   endfunction

   task automatic reset_predictor();
      win_now    = '0;
      row_cnt    = 0;
      col_cnt    = 0;
      flush_cnt  = 0;
      draining   = 1'b0;
      width_reg  = lbp_pkg::CFG_W'(lbp_pkg::RST_IMAGE_WIDTH);
      height_reg = lbp_pkg::CFG_W'(lbp_pkg::RST_IMAGE_HEIGHT);
      for (int i = 0; i < MAX_W; i++) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
   endtask

   task automatic predict_lbp(input lbp_pkg::req_type item);
      int unsigned               w;
      int unsigned               h;
      int unsigned               row;
      int unsigned               col;
      logic [lbp_pkg::PIX_W-1:0] top;
      logic [lbp_pkg::PIX_W-1:0] mid;
      logic [lbp_pkg::PIX_W-1:0] bot;
      lbp_pkg::rsp_type          made [2];
      int                        n;
      w   = clamp_dim(width_reg, MAX_W);
      h   = clamp_dim(height_reg, MAX_H);
      top = '0;
      mid = '0;
      n   = 0;
      if (item.kind == lbp_pkg::KIND_PIXEL && draining) return;
      if (item.kind == lbp_pkg::KIND_FLUSH && !draining) return;
      if (!draining) begin
         row = row_cnt;
         col = col_cnt;
         bot = item.pixel;
      end else begin
         row = h;
         col = flush_cnt;
         bot = '0;
      end
      if (col == 0) win_now = '0;
      if (col < MAX_W) begin
         if (row >= 2) top = upper_row[col];
         if (row >= 1) mid = middle_row[col];
         if (!draining) begin
            upper_row[col]  = middle_row[col];
            middle_row[col] = item.pixel;
         end
      end
      push_column(top, mid, bot);
      if (row >= 1 && col >= 1) begin
         made[n] = make_result(win_now, row - 1, col - 1, 1'b0);
         n++;
      end
      if (col + 1 >= w) begin
         if (row >= 1) begin
            push_column('0, '0, '0);
            made[n] = make_result(win_now, row - 1, col, draining);
            n++;
         end
         if (draining) begin
            row_cnt   = 0;
            col_cnt   = 0;
            flush_cnt = 0;
            draining  = 1'b0;
            win_now   = '0;
         end else begin
            col_cnt = 0;
            row_cnt = row + 1;
            if (row_cnt >= h) begin
               draining  = 1'b1;
               flush_cnt = 0;
               row_cnt   = 0;
            end
         end
      end else if (draining) begin
         flush_cnt = col + 1;
      end else begin
         col_cnt = col + 1;
      end
      if (n > 0) made[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) lbp_results_due.push_back(made[i]);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input bit unexpected, input lbp_pkg::rsp_type want,
                                  input lbp_pkg::rsp_type got);
      if (mismatches < 10) begin
         if (unexpected)
            $display("unexpected item: code %0d row %0d col %0d last %0d done %0d",
                     got.code, got.out_row, got.out_col, got.last_of_run, got.frame_done);
         else
            $display({"mismatch: exp code %0d row %0d col %0d last %0d done %0d",
                      " / got code %0d row %0d col %0d last %0d done %0d"},
                     want.code, want.out_row, want.out_col, want.last_of_run,
                     want.frame_done, got.code, got.out_row, got.out_col,
                     got.last_of_run, got.frame_done);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin : check_results
      lbp_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (lbp_results_due.size() == 0) begin
            report_mismatch(1'b1, '0, rsp_data);
         end else begin
            want = lbp_results_due.pop_front();
            if (want.code !== rsp_data.code || want.out_row !== rsp_data.out_row ||
                want.out_col !== rsp_data.out_col ||
                want.last_of_run !== rsp_data.last_of_run ||
                want.frame_done !== rsp_data.frame_done)
               report_mismatch(1'b0, want, rsp_data);
         end
      end
   end

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input lbp_pkg::req_type item);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      predict_lbp(item);
   endtask

   task automatic write_csr(input logic [lbp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [lbp_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == lbp_pkg::CSR_IMAGE_WIDTH) width_reg = value;
      else if (index == lbp_pkg::CSR_IMAGE_HEIGHT) height_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (lbp_results_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   function automatic lbp_pkg::req_type pixel_item(input logic [lbp_pkg::PIX_W-1:0] p);
      lbp_pkg::req_type it;
      it.kind  = lbp_pkg::KIND_PIXEL;
      it.pixel = p;
      return it;
   endfunction

   function automatic logic [lbp_pkg::PIX_W-1:0] rand_pixel();
      return lbp_pkg::PIX_W'($urandom_range(0, 255));
   endfunction

   function automatic lbp_pkg::req_type flush_item();
      lbp_pkg::req_type it;
      it.kind  = lbp_pkg::KIND_FLUSH;
      it.pixel = rand_pixel();
      return it;
   endfunction

   function automatic logic [lbp_pkg::PIX_W-1:0] draw_pixel(input pix_style_type s,
                                                            input logic [lbp_pkg::PIX_W-1:0] base);
      case (s)
         PIX_NARROW:  return lbp_pkg::PIX_W'(base + $urandom_range(0, 3));
         PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
         PIX_FLAT:    return ($urandom_range(0, 9) == 0) ? rand_pixel() : base;
         default:     return rand_pixel();
      endcase
   endfunction

   // pixels of one frame then the flush row, with optional stray items
   task automatic send_frame(input bit with_noise);
      int unsigned               w;
      int unsigned               h;
      pix_style_type             style;
      logic [lbp_pkg::PIX_W-1:0] base;
      w     = clamp_dim(width_reg, MAX_W);
      h     = clamp_dim(height_reg, MAX_H);
      style = pix_style_type'($urandom_range(0, 3));
      base  = lbp_pkg::PIX_W'($urandom_range(0, 252));
      for (int i = 0; i < w * h; i++) begin
         if (with_noise && $urandom_range(0, 49) == 0) send_item(flush_item());
         send_item(pixel_item(draw_pixel(style, base)));
      end
      for (int i = 0; i < w; i++) begin
         if (with_noise && $urandom_range(0, 19) == 0)
            send_item(pixel_item(rand_pixel()));
         send_item(flush_item());
      end
      items_counted += int'(w * h + w);
   endtask

   task automatic run_frame(input logic [lbp_pkg::CFG_W-1:0] w_val,
                            input logic [lbp_pkg::CFG_W-1:0] h_val,
                            input bit with_noise);
      wait_drained();
      write_csr(lbp_pkg::CSR_IMAGE_WIDTH, w_val);
      write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, h_val);
      send_frame(with_noise);
   endtask

   // ---------------------------------------------------------------- tests

   // part of a row at the reset width, then a narrower width ends that row
   task automatic test_reset_width();
      wait_drained();
      for (int i = 0; i < 60; i++) send_item(pixel_item(rand_pixel()));
      wait_drained();
      write_csr(lbp_pkg::CSR_IMAGE_WIDTH, 11'd8);
      write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, 11'd2);
      send_item(pixel_item(rand_pixel()));
      for (int i = 0; i < 8; i++) send_item(pixel_item(rand_pixel()));
      for (int i = 0; i < 8; i++) send_item(flush_item());
   endtask

   task automatic test_directed_patterns();
      logic [7:0] pattern [9];
      pattern = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd128, 8'd128, 8'd0, 8'd255, 8'd0};
      wait_drained();
      write_csr(CSR_UNUSED_2, 11'h7FF);
      write_csr(CSR_UNUSED_3, 11'h555);
      write_csr(lbp_pkg::CSR_IMAGE_WIDTH, 11'd3);
      write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, 11'd3);
      send_item(flush_item());
      for (int i = 0; i < 9; i++) begin
         send_item(pixel_item(pattern[i]));
         if (i == 4) send_item(flush_item());
      end
      send_item(pixel_item(8'hA5));
      repeat (3) send_item(flush_item());
      // zero sizes clamp to a single pixel frame
      wait_drained();
      write_csr(lbp_pkg::CSR_IMAGE_WIDTH, 11'd0);
      write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, 11'd0);
      send_item(pixel_item(8'd255));
      send_item(flush_item());
      send_item(pixel_item(8'd0));
      send_item(flush_item());
   endtask

   task automatic test_random_frames(input int budget);
      logic [lbp_pkg::CFG_W-1:0] w_val;
      logic [lbp_pkg::CFG_W-1:0] h_val;
      int                        stop_at;
      int                        pick;
      stop_at = items_counted + budget;
      while (items_counted < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) w_val = 11'd0;
         else if (pick < 12) w_val = lbp_pkg::CFG_W'($urandom_range(13, 40));
         else w_val = lbp_pkg::CFG_W'($urandom_range(1, 12));
         h_val = lbp_pkg::CFG_W'($urandom_range(0, 6));
         run_frame(w_val, h_val, 1'b1);
      end
   endtask

   // oversized sizes clamp to the maximum; the frame is closed by smaller sizes
   task automatic test_largest_frames();
      wait_drained();
      write_csr(lbp_pkg::CSR_IMAGE_WIDTH, 11'h7FF);
      write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, 11'd1025);
      for (int i = 0; i < 40; i++) send_item(pixel_item(rand_pixel()));
      wait_drained();
      write_csr(lbp_pkg::CSR_IMAGE_WIDTH, 11'd4);
      send_item(pixel_item(rand_pixel()));
      for (int i = 0; i < 4; i++) send_item(pixel_item(rand_pixel()));
      wait_drained();
      write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, 11'd3);
      for (int i = 0; i < 4; i++) send_item(pixel_item(rand_pixel()));
      for (int i = 0; i < 4; i++) send_item(flush_item());
   endtask

   initial begin
      reset_predictor();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 57;
      test_reset_width();
      test_directed_patterns();
      test_random_frames(210);

      send_idle_pct = 57;
      recv_idle_pct = 35;
      test_random_frames(210);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(210);
      test_largest_frames();

      wait_drained();
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
